// ----- rtl/core/pkv_pkg.sv -----
// Package for the paged KV slot mapper: field widths, item and result codes,
// and the queue entry passed from the front end to the back end.
// No dependencies.
`default_nettype none

package pkv_pkg;

  localparam int MAX_PAGE_SIZE_DEF = 32;
  localparam int MAX_BATCH_DEF     = 256;
  localparam int QUEUE_DEPTH       = 4;

  localparam int LEN_W   = 20;
  localparam int PID_W   = 16;
  localparam int SIZE_W  = 6;
  localparam int OFS_W   = 24;
  localparam int ENTRY_W = 21;
  localparam int BIDX_W  = 8;
  localparam int LO_W    = PID_W + SIZE_W;   // page start / page id times size

  typedef enum logic [1:0] {
    IK_BEGIN  = 2'd0,
    IK_HEADER = 2'd1,
    IK_PAGE   = 2'd2,
    IK_UNUSED = 2'd3
  } item_kind_t;

  localparam logic [1:0] RK_INDEX   = 2'd0;
  localparam logic [1:0] RK_SLOT    = 2'd1;
  localparam logic [1:0] RK_SUMMARY = 2'd2;

  // Classified work item handed to the back end
  typedef struct packed {
    item_kind_t          kind;
    logic [LEN_W-1:0]    total;
    logic [LEN_W-1:0]    new_cnt;   // clamped to total
    logic [LEN_W-1:0]    start;     // total - new_cnt
    logic [PID_W-1:0]    pages;     // page count, saturated
    logic [SIZE_W-1:0]   fill;      // tokens in last page, 0 for empty request
    logic                err;
    logic [PID_W-1:0]    pid;
  } pkv_entry_t;

endpackage

`default_nettype wire

// ----- rtl/core/paged_kv_slot_mapper.sv -----
// Paged KV slot mapper top: page size register, front end, queue and back end (pkv_pkg).
// A header runs through the front divider, waiting while the queue is full, before it
// enters the queue; a page item's first result is registered the cycle after it leaves
// the queue. One result transfer per cycle while result_stall is low; a page item gives
// an index, a slot per token and, on its last page, a summary; a header stalls the input.
// Reset: synchronous; page size returns to 16, all offsets and counters clear.
`default_nettype none

module paged_kv_slot_mapper
  import pkv_pkg::*;
#(
  parameter int MAX_PAGE_SIZE = MAX_PAGE_SIZE_DEF,
  parameter int MAX_BATCH     = MAX_BATCH_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               cfg_we,
  input  wire logic [SIZE_W-1:0]  cfg_wdata,
  input  wire logic               item_valid,
  output logic                    item_stall,
  input  wire logic [1:0]         kind,
  input  wire logic [LEN_W-1:0]   req_total,
  input  wire logic [LEN_W-1:0]   new_len,
  input  wire logic [PID_W-1:0]   page_id,
  output logic                    result_valid,
  input  wire logic               result_stall,
  output logic [1:0]              result_kind,
  output logic [BIDX_W-1:0]       batch_index,
  output logic [ENTRY_W-1:0]      entry_value,
  output logic [LEN_W-1:0]        token_position,
  output logic [OFS_W-1:0]        page_end_offset,
  output logic [OFS_W-1:0]        token_end_offset,
  output logic [SIZE_W-1:0]       last_page_fill,
  output logic                    length_error,
  output logic                    last
);

  logic [SIZE_W-1:0] tok_per_page;
  logic [SIZE_W-1:0] eff_size;
  logic              push;
  pkv_entry_t        push_entry;
  logic              full;
  logic              pop;
  pkv_entry_t        head;
  logic              head_valid;

  // Page size register; the value used is saturated to 1..MAX_PAGE_SIZE
  always_ff @(posedge clk) begin
    if (rst) begin
      tok_per_page <= SIZE_W'(16);
    end else if (cfg_we) begin
      tok_per_page <= cfg_wdata;
    end
  end

  assign eff_size = (tok_per_page == '0) ? SIZE_W'(1) :
                    ((tok_per_page > SIZE_W'(MAX_PAGE_SIZE)) ? SIZE_W'(MAX_PAGE_SIZE) :
                     tok_per_page);

  pkv_front u_front (
    .clk        (clk),
    .rst        (rst),
    .size       (eff_size),
    .item_valid (item_valid),
    .item_stall (item_stall),
    .kind       (kind),
    .req_total  (req_total),
    .new_len    (new_len),
    .page_id    (page_id),
    .push       (push),
    .push_entry (push_entry),
    .full       (full)
  );

  pkv_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .full       (full),
    .pop        (pop),
    .head       (head),
    .head_valid (head_valid)
  );

  pkv_back #(
    .MAX_BATCH (MAX_BATCH)
  ) u_back (
    .clk              (clk),
    .rst              (rst),
    .size             (eff_size),
    .head             (head),
    .head_valid       (head_valid),
    .pop              (pop),
    .result_valid     (result_valid),
    .result_stall     (result_stall),
    .result_kind      (result_kind),
    .batch_index      (batch_index),
    .entry_value      (entry_value),
    .token_position   (token_position),
    .page_end_offset  (page_end_offset),
    .token_end_offset (token_end_offset),
    .last_page_fill   (last_page_fill),
    .length_error     (length_error),
    .last             (last)
  );

endmodule

`default_nettype wire

// ----- rtl/core/pkv_front.sv -----
// Front end: accepts input items, runs the page-count division for request
// headers and pushes classified entries into the queue. Uses pkv_pkg.
`default_nettype none

module pkv_front
  import pkv_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic [SIZE_W-1:0] size,
  input  wire logic              item_valid,
  output logic                   item_stall,
  input  wire logic [1:0]        kind,
  input  wire logic [LEN_W-1:0]  req_total,
  input  wire logic [LEN_W-1:0]  new_len,
  input  wire logic [PID_W-1:0]  page_id,
  output logic                   push,
  output pkv_entry_t             push_entry,
  input  wire logic              full
);

  localparam int CNT_W = $clog2(LEN_W + 1);

  item_kind_t         in_kind;
  logic               accept;
  logic               div_busy;
  logic [CNT_W-1:0]   div_cnt;
  logic [SIZE_W-1:0]  div_rem;
  logic [LEN_W-1:0]   div_quo;
  logic [LEN_W-1:0]   hdr_total;
  logic [LEN_W-1:0]   hdr_new;
  logic [SIZE_W:0]    trial;
  logic               trial_ge;
  logic [SIZE_W-1:0]  rem_next;
  logic               div_done;
  logic [LEN_W:0]     np_full;
  logic               np_sat;
  logic               new_over;
  logic [LEN_W-1:0]   new_clamped;
  logic [SIZE_W-1:0]  fill;

  assign in_kind    = item_kind_t'(kind);
  assign item_stall = div_busy || full;
  assign accept     = item_valid && !item_stall;
  assign div_done   = div_busy && (div_cnt == '0);

  // One quotient bit per cycle, restoring division of total by page size
  assign trial    = {div_rem, div_quo[LEN_W-1]};
  assign trial_ge = trial >= {1'b0, size};
  assign rem_next = trial_ge ? SIZE_W'(trial - {1'b0, size}) : trial[SIZE_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      div_busy <= 1'b0;
      div_cnt  <= '0;
    end else if (accept && in_kind == IK_HEADER) begin
      div_busy <= 1'b1;
      div_cnt  <= CNT_W'(LEN_W);
    end else if (div_busy && div_cnt != '0) begin
      div_cnt  <= div_cnt - CNT_W'(1);
    end else if (div_done && !full) begin
      div_busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && in_kind == IK_HEADER) begin
      div_rem   <= '0;
      div_quo   <= req_total;
      hdr_total <= req_total;
      hdr_new   <= new_len;
    end else if (div_busy && div_cnt != '0) begin
      div_rem   <= rem_next;
      div_quo   <= {div_quo[LEN_W-2:0], trial_ge};
    end
  end

  // Header results: page count with rounding up, clamp, last page fill
  assign np_full     = {1'b0, div_quo} + (LEN_W + 1)'(div_rem != '0);
  assign np_sat      = np_full > (LEN_W + 1)'({PID_W{1'b1}});
  assign new_over    = hdr_new > hdr_total;
  assign new_clamped = new_over ? hdr_total : hdr_new;
  assign fill        = (hdr_total == '0) ? '0 : ((div_rem == '0) ? size : div_rem);

  // Queue push: finished header, or begin/page item taken straight through
  always_comb begin
    push       = 1'b0;
    push_entry = '0;
    if (div_busy) begin
      push               = div_done && !full;
      push_entry.kind    = IK_HEADER;
      push_entry.total   = hdr_total;
      push_entry.new_cnt = new_clamped;
      push_entry.start   = hdr_total - new_clamped;
      push_entry.pages   = np_sat ? {PID_W{1'b1}} : np_full[PID_W-1:0];
      push_entry.fill    = fill;
      push_entry.err     = new_over || np_sat;
    end else begin
      push               = accept && (in_kind == IK_BEGIN || in_kind == IK_PAGE);
      push_entry.kind    = in_kind;
      push_entry.pid     = page_id;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/pkv_queue.sv -----
// Short queue of classified entries between front end and back end.
// Uses pkv_pkg for the entry type and depth.
`default_nettype none

module pkv_queue
  import pkv_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  push,
  input  pkv_entry_t push_entry,
  output logic       full,
  input  wire logic  pop,
  output pkv_entry_t head,
  output logic       head_valid
);

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  pkv_entry_t        slots [QUEUE_DEPTH];
  logic [PTR_W-1:0]  wr_ptr;
  logic [PTR_W-1:0]  rd_ptr;
  logic [CNT_W-1:0]  count;

  assign full       = count == CNT_W'(QUEUE_DEPTH);
  assign head_valid = count != '0;
  assign head       = slots[rd_ptr];

  // Pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + CNT_W'(1);
      end else if (pop && !push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk) disable iff (rst) !(push && full))
    else $error("queue push while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst) !(pop && !head_valid))
    else $error("queue pop while empty");
`endif

endmodule

`default_nettype wire

// ----- rtl/core/pkv_back.sv -----
// Back end: holds the batch and request state, walks the tokens of each page
// and drives the registered result channel. Uses pkv_pkg.
`default_nettype none

module pkv_back
  import pkv_pkg::*;
#(
  parameter int MAX_BATCH = MAX_BATCH_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic [SIZE_W-1:0]  size,
  input  pkv_entry_t              head,
  input  wire logic               head_valid,
  output logic                    pop,
  output logic                    result_valid,
  input  wire logic               result_stall,
  output logic [1:0]              result_kind,
  output logic [BIDX_W-1:0]       batch_index,
  output logic [ENTRY_W-1:0]      entry_value,
  output logic [LEN_W-1:0]        token_position,
  output logic [OFS_W-1:0]        page_end_offset,
  output logic [OFS_W-1:0]        token_end_offset,
  output logic [SIZE_W-1:0]       last_page_fill,
  output logic                    length_error,
  output logic                    last
);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_TOK  = 3'b010,
    S_SUM  = 3'b100
  } state_t;

  state_t             state;
  logic [OFS_W-1:0]   page_sum;
  logic [OFS_W-1:0]   tok_sum;
  logic [BIDX_W-1:0]  req_cnt;
  logic [LEN_W-1:0]   cur_total;
  logic [LEN_W-1:0]   cur_new;
  logic [LEN_W-1:0]   cur_start;
  logic [PID_W-1:0]   pages_seen;
  logic [PID_W-1:0]   pages_exp;
  logic               cur_err;
  logic [SIZE_W-1:0]  cur_fill;
  logic [LO_W-1:0]    page_lo;
  logic [LO_W-1:0]    pid_mul;
  logic [LEN_W-1:0]   tok_p;
  logic [LEN_W-1:0]   tok_end;
  logic [SIZE_W-1:0]  tok_off;
  logic               sum_pending;

  logic               out_free;
  logic               take_head;
  logic               page_open;
  logic [PID_W-1:0]   seen_next;
  logic               will_sum;
  logic [LO_W:0]      page_hi;
  logic [LO_W-1:0]    tok_a;
  logic [LEN_W-1:0]   tok_b;
  logic               has_tok;
  logic               tok_last;
  logic [OFS_W-1:0]   pe_next;
  logic [OFS_W-1:0]   te_next;
  logic [BIDX_W-1:0]  req_next;

  logic               emit;
  logic [1:0]         r_kind;
  logic [ENTRY_W-1:0] r_entry;
  logic [LEN_W-1:0]   r_pos;
  logic [OFS_W-1:0]   r_pe;
  logic [OFS_W-1:0]   r_te;
  logic [SIZE_W-1:0]  r_fill;
  logic               r_last;

  assign out_free  = !result_valid || !result_stall;
  assign take_head = (state == S_IDLE) && head_valid && out_free;
  assign pop       = take_head;

  // Token range of the page at the queue head
  assign page_open = pages_seen < pages_exp;
  assign seen_next = pages_seen + PID_W'(1);
  assign will_sum  = seen_next >= pages_exp;
  assign page_hi   = {1'b0, page_lo} + (LO_W + 1)'(size);
  assign tok_a     = (page_lo > LO_W'(cur_start)) ? page_lo : LO_W'(cur_start);
  assign tok_b     = ((LO_W + 1)'(cur_total) < page_hi) ? cur_total : page_hi[LEN_W-1:0];
  assign has_tok   = LO_W'(tok_b) > tok_a;
  assign tok_last  = LEN_W'(tok_p + LEN_W'(1)) == tok_end;

  // Summary values and batch counter wrap
  assign pe_next  = page_sum + OFS_W'(pages_exp);
  assign te_next  = tok_sum + OFS_W'(cur_new);
  assign req_next = ((32'(req_cnt) + 32'd1) >= 32'(MAX_BATCH)) ? '0 : req_cnt + BIDX_W'(1);

  // Result selection
  always_comb begin
    emit    = 1'b0;
    r_kind  = RK_INDEX;
    r_entry = '0;
    r_pos   = '0;
    r_pe    = '0;
    r_te    = '0;
    r_fill  = '0;
    r_last  = 1'b0;
    unique case (state)
      S_IDLE: begin
        if (take_head && head.kind == IK_PAGE && page_open) begin
          emit    = 1'b1;
          r_kind  = RK_INDEX;
          r_entry = ENTRY_W'(head.pid);
          r_last  = !has_tok && !will_sum;
        end
      end
      S_TOK: begin
        emit    = out_free;
        r_kind  = RK_SLOT;
        r_entry = ENTRY_W'(pid_mul + LO_W'(tok_off));
        r_pos   = tok_p;
        r_last  = tok_last && !sum_pending;
      end
      S_SUM: begin
        emit    = out_free;
        r_kind  = RK_SUMMARY;
        r_pe    = pe_next;
        r_te    = te_next;
        r_fill  = cur_fill;
        r_last  = 1'b1;
      end
      default: begin
        emit    = 1'b0;
      end
    endcase
  end

  // Sequencer and request state
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      page_sum    <= '0;
      tok_sum     <= '0;
      req_cnt     <= '0;
      cur_total   <= '0;
      cur_new     <= '0;
      cur_start   <= '0;
      pages_seen  <= '0;
      pages_exp   <= '0;
      cur_err     <= 1'b0;
      cur_fill    <= '0;
      page_lo     <= '0;
      pid_mul     <= '0;
      tok_p       <= '0;
      tok_end     <= '0;
      tok_off     <= '0;
      sum_pending <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (take_head) begin
            unique case (head.kind)
              IK_BEGIN: begin
                page_sum   <= '0;
                tok_sum    <= '0;
                req_cnt    <= '0;
                cur_total  <= '0;
                cur_new    <= '0;
                cur_start  <= '0;
                pages_seen <= '0;
                pages_exp  <= '0;
                cur_err    <= 1'b0;
                cur_fill   <= '0;
                page_lo    <= '0;
              end
              IK_HEADER: begin
                cur_total  <= head.total;
                cur_new    <= head.new_cnt;
                cur_start  <= head.start;
                pages_seen <= '0;
                pages_exp  <= head.pages;
                cur_err    <= head.err;
                cur_fill   <= head.fill;
                page_lo    <= '0;
                if (head.total == '0) begin
                  state <= S_SUM;
                end
              end
              IK_PAGE: begin
                if (page_open) begin
                  pages_seen  <= seen_next;
                  page_lo     <= page_lo + LO_W'(size);
                  pid_mul     <= LO_W'(head.pid) * LO_W'(size);
                  sum_pending <= will_sum;
                  tok_p       <= tok_a[LEN_W-1:0];
                  tok_end     <= tok_b;
                  tok_off     <= SIZE_W'(tok_a - page_lo);
                  if (has_tok) begin
                    state <= S_TOK;
                  end else if (will_sum) begin
                    state <= S_SUM;
                  end
                end
              end
              IK_UNUSED: begin
                state <= S_IDLE;
              end
            endcase
          end
        end
        S_TOK: begin
          if (out_free) begin
            tok_p   <= tok_p + LEN_W'(1);
            tok_off <= tok_off + SIZE_W'(1);
            if (tok_last) begin
              state <= sum_pending ? S_SUM : S_IDLE;
            end
          end
        end
        S_SUM: begin
          if (out_free) begin
            page_sum   <= pe_next;
            tok_sum    <= te_next;
            req_cnt    <= req_next;
            pages_seen <= '0;
            pages_exp  <= '0;
            state      <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (emit) begin
      result_valid <= 1'b1;
    end else if (out_free) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      result_kind      <= r_kind;
      batch_index      <= req_cnt;
      entry_value      <= r_entry;
      token_position   <= r_pos;
      page_end_offset  <= r_pe;
      token_end_offset <= r_te;
      last_page_fill   <= r_fill;
      length_error     <= cur_err;
      last             <= r_last;
    end
  end

`ifndef SYNTHESIS
  a_tok_range: assert property (@(posedge clk) disable iff (rst)
    state == S_TOK |-> tok_p < tok_end)
    else $error("token walk beyond page range");
  a_pages_bound: assert property (@(posedge clk) disable iff (rst)
    pages_seen <= pages_exp)
    else $error("more pages seen than expected");
  a_summary_last: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_kind == RK_SUMMARY |-> last)
    else $error("summary transfer without last");
`endif

endmodule

`default_nettype wire
